FILE: sv/atsu_pkg.sv
// shared types, codes and character helpers for the assembly token scanner
`timescale 1ns / 1ps

package atsu_pkg;

    localparam int LINE_BITS_DEF   = 16;
    localparam int COLUMN_BITS_DEF = 12;
    localparam int LINE_OUT_W      = 16;
    localparam int COL_OUT_W       = 12;
    localparam int LEN_W           = 12;
    localparam int KIND_W          = 4;
    localparam int TDATA_OUT_W     = 48;
    localparam int TUSER_OUT_W     = 4;
    localparam int Q_DEPTH         = 4;

    // token kinds
    localparam logic [KIND_W-1:0] KIND_IDENT   = 4'd0;
    localparam logic [KIND_W-1:0] KIND_KEYWORD = 4'd1;
    localparam logic [KIND_W-1:0] KIND_INT     = 4'd2;
    localparam logic [KIND_W-1:0] KIND_FLOAT   = 4'd3;
    localparam logic [KIND_W-1:0] KIND_STRING  = 4'd4;
    localparam logic [KIND_W-1:0] KIND_COLON   = 4'd5;
    localparam logic [KIND_W-1:0] KIND_COMMA   = 4'd6;
    localparam logic [KIND_W-1:0] KIND_SLASH   = 4'd7;
    localparam logic [KIND_W-1:0] KIND_LPAREN  = 4'd8;
    localparam logic [KIND_W-1:0] KIND_RPAREN  = 4'd9;
    localparam logic [KIND_W-1:0] KIND_END     = 4'd10;
    localparam logic [KIND_W-1:0] KIND_BAD     = 4'd11;

    // keyword selectors
    localparam logic KW_BEGIN = 1'b0;
    localparam logic KW_END   = 1'b1;

    // characters with a role of their own
    localparam logic [7:0] CH_EOI    = 8'd255;
    localparam logic [7:0] CH_SQUOTE = 8'd39;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_UNDER  = 8'h5f;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_E      = 8'h45;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic                  kw;
        logic [LINE_OUT_W-1:0] line;
        logic [COL_OUT_W-1:0]  col;
        logic [LEN_W-1:0]      len;
        logic                  last;
    } token_t;

    // tokens produced by one character, slot 0 first
    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } step_out_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
               c == CH_UNDER || c == CH_AT;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [7:0] kw_begin_char(input logic [2:0] idx);
        logic [7:0] r;
        unique case (idx)
            3'd0:    r = 8'h42;
            3'd1:    r = 8'h45;
            3'd2:    r = 8'h47;
            3'd3:    r = 8'h49;
            3'd4:    r = 8'h4e;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kw_end_char(input logic [1:0] idx);
        logic [7:0] r;
        unique case (idx)
            2'd0:    r = 8'h45;
            2'd1:    r = 8'h4e;
            2'd2:    r = 8'h44;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

FILE: sv/atsu_core.sv
// scanner state, position counters and per-character token decision
`timescale 1ns / 1ps

module atsu_core #(
    parameter int LINE_BITS   = atsu_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = atsu_pkg::COLUMN_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  logic [7:0]          char_byte,
    input  logic                end_of_input,
    output atsu_pkg::step_out_t step_out
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_IDENT   = 4'd1;
    localparam logic [3:0] ST_INT     = 4'd2;
    localparam logic [3:0] ST_FLOAT   = 4'd3;
    localparam logic [3:0] ST_MINUS   = 4'd4;
    localparam logic [3:0] ST_SQUOTE  = 4'd5;
    localparam logic [3:0] ST_DQUOTE  = 4'd6;
    localparam logic [3:0] ST_COMMENT = 4'd7;

    localparam logic [atsu_pkg::LEN_W-1:0] LEN_MAX = '1;

    logic [3:0]                  st_reg, st_next;
    logic [LINE_BITS-1:0]        line_reg, line_next;
    logic [COLUMN_BITS-1:0]      col_reg, col_next;
    logic [LINE_BITS-1:0]        tsl_reg, tsl_next;
    logic [COLUMN_BITS-1:0]      tsc_reg, tsc_next;
    logic [atsu_pkg::LEN_W-1:0]  len_reg, len_next;
    logic                        bm_reg, bm_next;
    logic                        em_reg, em_next;

    logic                        eoi, letter, digit, nl;
    logic                        close_en, idle_en, adv, grow, match;
    logic [atsu_pkg::KIND_W-1:0] close_kind, idle_kind;
    logic                        idle_tok;
    logic [atsu_pkg::LEN_W-1:0]  idle_len;
    logic [31:0]                 line_w, col_w, tsl_w, tsc_w;
    atsu_pkg::token_t            ctok, itok;

    assign eoi    = end_of_input || char_byte == atsu_pkg::CH_EOI;
    assign letter = atsu_pkg::is_letter(char_byte);
    assign digit  = atsu_pkg::is_digit(char_byte);
    assign nl     = char_byte == atsu_pkg::CH_NL;

    // output fields are the low bits of the counters
    assign line_w = 32'(line_reg);
    assign col_w  = 32'(col_reg);
    assign tsl_w  = 32'(tsl_reg);
    assign tsc_w  = 32'(tsc_reg);

    always_comb begin
        st_next    = st_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        tsl_next   = tsl_reg;
        tsc_next   = tsc_reg;
        len_next   = len_reg;
        bm_next    = bm_reg;
        em_next    = em_reg;
        close_en   = 1'b0;
        close_kind = atsu_pkg::KIND_IDENT;
        idle_en    = 1'b0;
        adv        = 1'b0;
        grow       = 1'b0;
        match      = 1'b0;
        idle_tok   = 1'b0;
        idle_kind  = atsu_pkg::KIND_BAD;
        idle_len   = atsu_pkg::LEN_W'(1);

        unique case (st_reg)
            ST_IDENT: begin
                if (!eoi && (letter || digit)) begin
                    match = 1'b1;
                    grow  = 1'b1;
                    adv   = 1'b1;
                end else begin
                    close_en   = 1'b1;
                    close_kind = atsu_pkg::KIND_IDENT;
                    idle_en    = 1'b1;
                end
            end
            ST_INT: begin
                if (!eoi && digit) begin
                    grow = 1'b1;
                    adv  = 1'b1;
                end else if (!eoi && char_byte == atsu_pkg::CH_DOT) begin
                    st_next = ST_FLOAT;
                    grow    = 1'b1;
                    adv     = 1'b1;
                end else begin
                    close_en   = 1'b1;
                    close_kind = atsu_pkg::KIND_INT;
                    idle_en    = 1'b1;
                end
            end
            ST_FLOAT: begin
                if (!eoi && digit) begin
                    grow = 1'b1;
                    adv  = 1'b1;
                end else begin
                    close_en   = 1'b1;
                    close_kind = atsu_pkg::KIND_FLOAT;
                    idle_en    = 1'b1;
                end
            end
            ST_MINUS: begin
                if (!eoi && digit) begin
                    st_next = ST_INT;
                    grow    = 1'b1;
                    adv     = 1'b1;
                end else begin
                    close_en   = 1'b1;
                    close_kind = atsu_pkg::KIND_BAD;
                    idle_en    = 1'b1;
                end
            end
            ST_SQUOTE, ST_DQUOTE: begin
                if (eoi) begin
                    close_en   = 1'b1;
                    close_kind = atsu_pkg::KIND_BAD;
                    idle_en    = 1'b1;
                end else if ((st_reg == ST_SQUOTE && char_byte == atsu_pkg::CH_SQUOTE) ||
                             (st_reg == ST_DQUOTE && char_byte == atsu_pkg::CH_DQUOTE)) begin
                    close_en   = 1'b1;
                    close_kind = atsu_pkg::KIND_STRING;
                    adv        = 1'b1;
                end else begin
                    grow = 1'b1;
                    adv  = 1'b1;
                end
            end
            ST_COMMENT: begin
                if (eoi) begin
                    idle_en = 1'b1;
                end else begin
                    if (nl) begin
                        st_next = ST_IDLE;
                    end
                    adv = 1'b1;
                end
            end
            default: begin
                idle_en = 1'b1;
            end
        endcase

        if (close_en) begin
            st_next = ST_IDLE;
        end

        if (match) begin
            bm_next = bm_reg && len_reg < atsu_pkg::LEN_W'(5) &&
                      char_byte == atsu_pkg::kw_begin_char(len_reg[2:0]);
            em_next = em_reg && len_reg < atsu_pkg::LEN_W'(3) &&
                      char_byte == atsu_pkg::kw_end_char(len_reg[1:0]);
        end
        if (grow && len_reg != LEN_MAX) begin
            len_next = len_reg + atsu_pkg::LEN_W'(1);
        end

        // character scanned from idle, possibly right after a close
        if (idle_en) begin
            st_next = ST_IDLE;
            if (eoi) begin
                idle_tok  = 1'b1;
                idle_kind = atsu_pkg::KIND_END;
                idle_len  = '0;
            end else begin
                adv = 1'b1;
                priority if (letter) begin
                    st_next  = ST_IDENT;
                    tsl_next = line_reg;
                    tsc_next = col_reg;
                    len_next = atsu_pkg::LEN_W'(1);
                    bm_next  = char_byte == atsu_pkg::CH_B;
                    em_next  = char_byte == atsu_pkg::CH_E;
                end else if (digit || char_byte == atsu_pkg::CH_MINUS) begin
                    st_next  = digit ? ST_INT : ST_MINUS;
                    tsl_next = line_reg;
                    tsc_next = col_reg;
                    len_next = atsu_pkg::LEN_W'(1);
                    bm_next  = 1'b1;
                    em_next  = 1'b1;
                end else if (char_byte == atsu_pkg::CH_SQUOTE ||
                             char_byte == atsu_pkg::CH_DQUOTE) begin
                    st_next  = (char_byte == atsu_pkg::CH_SQUOTE) ? ST_SQUOTE : ST_DQUOTE;
                    tsl_next = line_reg;
                    tsc_next = col_reg;
                    len_next = '0;
                    bm_next  = 1'b1;
                    em_next  = 1'b1;
                end else if (char_byte == atsu_pkg::CH_SEMI) begin
                    st_next = ST_COMMENT;
                end else if (char_byte == atsu_pkg::CH_COLON) begin
                    idle_tok  = 1'b1;
                    idle_kind = atsu_pkg::KIND_COLON;
                end else if (char_byte == atsu_pkg::CH_COMMA) begin
                    idle_tok  = 1'b1;
                    idle_kind = atsu_pkg::KIND_COMMA;
                end else if (char_byte == atsu_pkg::CH_SLASH) begin
                    idle_tok  = 1'b1;
                    idle_kind = atsu_pkg::KIND_SLASH;
                end else if (char_byte == atsu_pkg::CH_LPAREN) begin
                    idle_tok  = 1'b1;
                    idle_kind = atsu_pkg::KIND_LPAREN;
                end else if (char_byte == atsu_pkg::CH_RPAREN) begin
                    idle_tok  = 1'b1;
                    idle_kind = atsu_pkg::KIND_RPAREN;
                end else if (char_byte == atsu_pkg::CH_SPACE ||
                             char_byte == atsu_pkg::CH_TAB || nl) begin
                    idle_tok = 1'b0;
                end else begin
                    idle_tok  = 1'b1;
                    idle_kind = atsu_pkg::KIND_BAD;
                end
            end
        end

        // position moves after the tokens have taken the current one
        if (adv) begin
            if (nl) begin
                if (line_reg != {LINE_BITS{1'b1}}) begin
                    line_next = line_reg + LINE_BITS'(1);
                end
                col_next = '0;
            end else if (col_reg != {COLUMN_BITS{1'b1}}) begin
                col_next = col_reg + COLUMN_BITS'(1);
            end
        end
    end

    // token built from the closing word, keyword check on identifiers
    always_comb begin
        ctok.kind = close_kind;
        ctok.kw   = atsu_pkg::KW_BEGIN;
        if (close_kind == atsu_pkg::KIND_IDENT) begin
            if (bm_reg && len_reg == atsu_pkg::LEN_W'(5)) begin
                ctok.kind = atsu_pkg::KIND_KEYWORD;
                ctok.kw   = atsu_pkg::KW_BEGIN;
            end else if (em_reg && len_reg == atsu_pkg::LEN_W'(3)) begin
                ctok.kind = atsu_pkg::KIND_KEYWORD;
                ctok.kw   = atsu_pkg::KW_END;
            end
        end
        ctok.line = tsl_w[atsu_pkg::LINE_OUT_W-1:0];
        ctok.col  = tsc_w[atsu_pkg::COL_OUT_W-1:0];
        ctok.len  = len_reg;
        ctok.last = !idle_tok;

        itok.kind = idle_kind;
        itok.kw   = atsu_pkg::KW_BEGIN;
        itok.line = line_w[atsu_pkg::LINE_OUT_W-1:0];
        itok.col  = col_w[atsu_pkg::COL_OUT_W-1:0];
        itok.len  = idle_len;
        itok.last = 1'b1;
    end

    always_comb begin
        step_out.count = 2'({1'b0, close_en} + {1'b0, idle_tok});
        step_out.tok0  = close_en ? ctok : itok;
        step_out.tok1  = itok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= ST_IDLE;
            line_reg <= LINE_BITS'(1);
            col_reg  <= '0;
            tsl_reg  <= LINE_BITS'(1);
            tsc_reg  <= '0;
            len_reg  <= '0;
            bm_reg   <= 1'b1;
            em_reg   <= 1'b1;
        end else if (step_en) begin
            st_reg   <= st_next;
            line_reg <= line_next;
            col_reg  <= col_next;
            tsl_reg  <= tsl_next;
            tsc_reg  <= tsc_next;
            len_reg  <= len_next;
            bm_reg   <= bm_next;
            em_reg   <= em_next;
        end
    end

    // line is one-based and saturates, so it never reads zero
    a_line_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        line_reg != '0)
        else $error("line counter reached zero");

    // exactly the final token of a character carries the last flag
    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_out.count == 2'd2) |-> (!step_out.tok0.last && step_out.tok1.last))
        else $error("two-token step has wrong last flags");

    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_out.count == 2'd1) |-> step_out.tok0.last)
        else $error("single token not marked last");

endmodule

FILE: sv/atsu_queue.sv
// four-entry token queue, takes up to two tokens a cycle, drives the result stream
`timescale 1ns / 1ps

module atsu_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_en,
    input  atsu_pkg::step_out_t push_data,
    input  logic                pop_en,
    output logic                room,
    output logic                head_valid,
    output atsu_pkg::token_t    head
);

    localparam int PTR_W = $clog2(atsu_pkg::Q_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    atsu_pkg::token_t mem_reg [atsu_pkg::Q_DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] n_push;
    logic [PTR_W-1:0] wr_plus1;

    assign n_push     = push_en ? CNT_W'(push_data.count) : '0;
    assign wr_plus1   = wr_reg + PTR_W'(1);
    assign head_valid = cnt_reg != '0;
    assign head       = mem_reg[rd_reg];

    // two free slots are needed, counting the entry leaving this cycle
    assign room = (cnt_reg <= CNT_W'(atsu_pkg::Q_DEPTH - 2)) ||
                  (cnt_reg == CNT_W'(atsu_pkg::Q_DEPTH - 1) && pop_en);

    always_ff @(posedge aclk) begin
        if (n_push != '0) begin
            mem_reg[wr_reg] <= push_data.tok0;
        end
        if (n_push == CNT_W'(2)) begin
            mem_reg[wr_plus1] <= push_data.tok1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_reg + PTR_W'(n_push);
            if (pop_en) begin
                rd_reg <= rd_reg + PTR_W'(1);
            end
            cnt_reg <= cnt_reg + n_push - CNT_W'(pop_en);
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(atsu_pkg::Q_DEPTH))
        else $error("token queue overflow");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_en |-> head_valid)
        else $error("pop from empty token queue");

    // a waiting token only leaves through a pop
    a_head_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_valid && !pop_en) |=> head_valid)
        else $error("queued token vanished without a pop");

endmodule

FILE: sv/assembly_token_scanner_unit.sv
// top level of the assembly token scanner: input stage, scanner core, token queue
`timescale 1ns / 1ps

// channel   dir  beat                                  notes
// s_axis    in   one source character                  tlast = end of input
// m_axis    out  one token                             tlast = final token of a character
//
// one character is taken per cycle while the token queue has room; a character that
// closes a token and starts a single-character, bad or end token yields two beats on m_axis
// the character register feeds the core only when the token queue has two free
// slots, so a stalled m_axis backs up into s_axis_tready once three or four
// tokens wait in the queue and one more character is held in the register
// aresetn is synchronous, active low: idle state, line one, column zero
// a character passes the character register and the scanner core, and its tokens are
// registered in the token queue and offered once the tokens queued ahead of them have gone

module assembly_token_scanner_unit #(
    parameter int LINE_BITS   = atsu_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = atsu_pkg::COLUMN_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // fields from bit 0: char_byte[7:0]
    input  logic [7:0]                          s_axis_tdata,
    input  logic                                s_axis_tlast,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // fields from bit 0: keyword_index[0], start_line[16:1], start_column[28:17],
    // token_length[40:29], zero fill[47:41]
    output logic [atsu_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
    // fields from bit 0: token_kind[3:0]
    output logic [atsu_pkg::TUSER_OUT_W-1:0]    m_axis_tuser,
    output logic                                m_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready
);

    logic                in_valid_reg;
    logic [7:0]          in_char_reg;
    logic                in_eoi_reg;
    logic                step_en;
    logic                room;
    logic                pop_en;
    logic                head_valid;
    atsu_pkg::token_t    head;
    atsu_pkg::step_out_t step_out;

    assign pop_en        = head_valid && m_axis_tready;
    // the held character moves on as soon as the queue can take its tokens
    assign step_en       = in_valid_reg && room;
    assign s_axis_tready = !in_valid_reg || step_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // character payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_char_reg <= s_axis_tdata;
            in_eoi_reg  <= s_axis_tlast;
        end
    end

    atsu_core #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (step_en),
        .char_byte    (in_char_reg),
        .end_of_input (in_eoi_reg),
        .step_out     (step_out)
    );

    atsu_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_en    (step_en),
        .push_data  (step_out),
        .pop_en     (pop_en),
        .room       (room),
        .head_valid (head_valid),
        .head       (head)
    );

    // result beat packing
    assign m_axis_tvalid = head_valid;
    assign m_axis_tlast  = head.last;
    assign m_axis_tuser  = head.kind;
    assign m_axis_tdata  = {7'b0, head.len, head.col, head.line, head.kw};

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for the assembly token scanner: directed table, random source text
`timescale 1ns / 1ps

module tb_top;
    import atsu_pkg::*;

    localparam int RANDOM_CHARS = 1570;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_LIMIT  = 4000;
    localparam int REPORT_MAX   = 10;

    localparam logic [39:0] WORD_BEGIN = "BEGIN";
    localparam logic [23:0] WORD_END   = "END";

    // scanner states as the predictor tracks them
    typedef enum logic [3:0] {
        SC_IDLE, SC_WORD, SC_NUM, SC_FRAC, SC_SIGN, SC_SQUOTE, SC_DQUOTE, SC_NOTE
    } scan_t;

    // one line of the directed table; given_ok marks a token typed in by hand
    typedef struct {
        logic [7:0] c;
        logic       eoi;
        bit         given_ok;
        token_t     given;
    } row_t;

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic [7:0]             s_axis_tdata  = 8'h00;
    logic                   s_axis_tlast  = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;
    logic [TUSER_OUT_W-1:0] m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;

    // predictor copy of the scanner state
    scan_t       sc;
    logic [15:0] cur_line, tok_line;
    logic [11:0] cur_col, tok_col, lex_len;
    logic        begin_ok, end_ok;

    token_t      staged[$];        // tokens caused by the character being scanned
    token_t      tok_expected[$];  // tokens still owed by the block, oldest first
    row_t        plan[$];

    bit          no_idle = 1'b0;   // both sides run flat out while set
    int          chars_sent = 0;
    int          fail_count = 0;
    int          kind_seen[16];
    int          rx_wait = 0;
    int unsigned cycles = 0;

    assembly_token_scanner_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    always #5 aclk = ~aclk;

    // hard stop in case the block hangs
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d tokens still owed", cycles,
                     tok_expected.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------- helpers

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               c == CH_UNDER || c == CH_AT;
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic string tok_text(token_t t);
        return $sformatf("kind=%0d kw=%0d line=%0d col=%0d len=%0d last=%0d",
                         t.kind, t.kw, t.line, t.col, t.len, t.last);
    endfunction

    task automatic report_failure(string what);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("[%0t] %s", $time, what);
    endtask

    // ------------------------------------------------------------- predictor

    task automatic stage(logic [3:0] kind, logic kw, logic [15:0] line,
                         logic [11:0] col, logic [11:0] len);
        token_t t;
        t.kind = kind;
        t.kw   = kw;
        t.line = line;
        t.col  = col;
        t.len  = len;
        t.last = 1'b0;
        staged.push_back(t);
    endtask

    // position moves on after every consumed character, both counters saturate
    task automatic step_pos(logic [7:0] c);
        if (c == CH_NL) begin
            if (cur_line != 16'hFFFF) cur_line++;
            cur_col = '0;
        end else if (cur_col != 12'hFFF) begin
            cur_col++;
        end
    endtask

    task automatic lex_grow();
        if (lex_len != 12'hFFF) lex_len++;
    endtask

    // keyword candidates die on the first character that breaks the spelling
    task automatic lex_match(logic [7:0] c);
        int p;
        p = int'(lex_len);
        begin_ok = begin_ok && p < 5 && c == WORD_BEGIN[8*(4-p) +: 8];
        end_ok   = end_ok && p < 3 && c == WORD_END[8*(2-p) +: 8];
    endtask

    task automatic open_tok(scan_t st, logic [11:0] len);
        sc       = st;
        tok_line = cur_line;
        tok_col  = cur_col;
        lex_len  = len;
        begin_ok = 1'b1;
        end_ok   = 1'b1;
    endtask

    task automatic close_tok(logic [3:0] kind_in);
        logic [3:0] k;
        logic       kw;
        k  = kind_in;
        kw = 1'b0;
        if (k == KIND_IDENT) begin
            if (begin_ok && lex_len == 12'd5) begin
                k  = KIND_KEYWORD;
                kw = KW_BEGIN;
            end else if (end_ok && lex_len == 12'd3) begin
                k  = KIND_KEYWORD;
                kw = KW_END;
            end
        end
        stage(k, kw, tok_line, tok_col, lex_len);
        sc = SC_IDLE;
    endtask

    // a character seen with no token open
    task automatic from_idle(logic [7:0] c, logic eoi);
        logic [15:0] l;
        logic [11:0] col;
        l   = cur_line;
        col = cur_col;
        sc  = SC_IDLE;
        if (eoi) begin
            stage(KIND_END, 1'b0, l, col, 12'd0);
        end else begin
            if (is_alpha(c)) begin
                open_tok(SC_WORD, 12'd0);
                lex_match(c);
                lex_grow();
            end else if (is_num(c)) begin
                open_tok(SC_NUM, 12'd1);
            end else if (c == CH_MINUS) begin
                open_tok(SC_SIGN, 12'd1);
            end else if (c == CH_SQUOTE) begin
                open_tok(SC_SQUOTE, 12'd0);
            end else if (c == CH_DQUOTE) begin
                open_tok(SC_DQUOTE, 12'd0);
            end else if (c == CH_SEMI) begin
                sc = SC_NOTE;
            end else if (c == CH_COLON) begin
                stage(KIND_COLON, 1'b0, l, col, 12'd1);
            end else if (c == CH_COMMA) begin
                stage(KIND_COMMA, 1'b0, l, col, 12'd1);
            end else if (c == CH_SLASH) begin
                stage(KIND_SLASH, 1'b0, l, col, 12'd1);
            end else if (c == CH_LPAREN) begin
                stage(KIND_LPAREN, 1'b0, l, col, 12'd1);
            end else if (c == CH_RPAREN) begin
                stage(KIND_RPAREN, 1'b0, l, col, 12'd1);
            end else if (c == CH_SPACE || c == CH_TAB || c == CH_NL) begin
                // whitespace only moves the position
            end else begin
                stage(KIND_BAD, 1'b0, l, col, 12'd1);
            end
            step_pos(c);
        end
    endtask

    // scan one character, leaving the tokens it causes in staged
    task automatic scan_char(logic [7:0] c, logic eoi_in);
        logic eoi;
        eoi = eoi_in || (c == CH_EOI);
        case (sc)
            SC_WORD: begin
                if (!eoi && (is_alpha(c) || is_num(c))) begin
                    lex_match(c);
                    lex_grow();
                    step_pos(c);
                end else begin
                    close_tok(KIND_IDENT);
                    from_idle(c, eoi);
                end
            end
            SC_NUM: begin
                if (!eoi && is_num(c)) begin
                    lex_grow();
                    step_pos(c);
                end else if (!eoi && c == CH_DOT) begin
                    // a dot after digits makes it a float
                    sc = SC_FRAC;
                    lex_grow();
                    step_pos(c);
                end else begin
                    close_tok(KIND_INT);
                    from_idle(c, eoi);
                end
            end
            SC_FRAC: begin
                if (!eoi && is_num(c)) begin
                    lex_grow();
                    step_pos(c);
                end else begin
                    close_tok(KIND_FLOAT);
                    from_idle(c, eoi);
                end
            end
            SC_SIGN: begin
                if (!eoi && is_num(c)) begin
                    sc = SC_NUM;
                    lex_grow();
                    step_pos(c);
                end else begin
                    // lone minus
                    close_tok(KIND_BAD);
                    from_idle(c, eoi);
                end
            end
            SC_SQUOTE, SC_DQUOTE: begin
                if (eoi) begin
                    close_tok(KIND_BAD);
                    from_idle(c, eoi);
                end else if ((sc == SC_SQUOTE && c == CH_SQUOTE) ||
                             (sc == SC_DQUOTE && c == CH_DQUOTE)) begin
                    close_tok(KIND_STRING);
                    step_pos(c);
                end else begin
                    lex_grow();
                    step_pos(c);
                end
            end
            SC_NOTE: begin
                if (eoi) begin
                    from_idle(c, eoi);
                end else begin
                    if (c == CH_NL) sc = SC_IDLE;
                    step_pos(c);
                end
            end
            default: from_idle(c, eoi);
        endcase
    endtask

    // ------------------------------------------------------------ input side

    // one character beat; the predictor runs at the edge that accepts it
    task automatic send_char(logic [7:0] c, logic eoi, bit given_ok, token_t given);
        int     gap;
        token_t t;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eoi;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        scan_char(c, eoi);
        if (given_ok) begin
            tok_expected.push_back(given);
        end else begin
            for (int i = 0; i < staged.size(); i++) begin
                t      = staged[i];
                t.last = (i == staged.size() - 1);
                tok_expected.push_back(t);
            end
        end
        staged.delete();
        chars_sent++;
    endtask

    task automatic put(logic [7:0] c, logic eoi);
        send_char(c, eoi, 1'b0, '0);
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++) put(s[i], 1'b0);
    endtask

    function automatic logic [7:0] rand_alpha();
        int r;
        r = $urandom_range(0, 53);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        return (r == 52) ? CH_UNDER : CH_AT;
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_alnum();
        return ($urandom_range(0, 3) == 0) ? rand_digit() : rand_alpha();
    endfunction

    // one random lexeme, mostly well formed, followed by a random separator or by none
    task automatic random_token();
        int         pick;
        int         n;
        logic [7:0] q;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            case ($urandom_range(0, 9))
                0:       put_text("BEGIN");
                1:       put_text("END");
                2:       put_text("BEGI");
                3:       put_text("ENDS");
                4:       put_text("BEGIN9");
                5:       put_text("EN");
                6:       put_text("end");
                default: begin
                    put(rand_alpha(), 1'b0);
                    n = $urandom_range(0, 8);
                    repeat (n) put(rand_alnum(), 1'b0);
                end
            endcase
        end else if (pick < 45) begin
            // signed numbers, some with a fraction
            if ($urandom_range(0, 2) == 0) put(CH_MINUS, 1'b0);
            n = $urandom_range(1, 6);
            repeat (n) put(rand_digit(), 1'b0);
            if ($urandom_range(0, 2) == 0) begin
                put(CH_DOT, 1'b0);
                n = $urandom_range(0, 4);
                repeat (n) put(rand_digit(), 1'b0);
            end
        end else if (pick < 55) begin
            // quoted strings with arbitrary content, a few left open at end of input
            q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
            put(q, 1'b0);
            n = $urandom_range(0, 8);
            repeat (n) begin
                b = 8'($urandom_range(0, 254));
                if (b == q) b = "a";
                if ($urandom_range(0, 7) == 0) b = CH_NL;
                put(b, 1'b0);
            end
            if ($urandom_range(0, 9) == 0) put(8'($urandom_range(0, 255)), 1'b1);
            else put(q, 1'b0);
        end else if (pick < 70) begin
            case ($urandom_range(0, 4))
                0:       put(CH_COLON, 1'b0);
                1:       put(CH_COMMA, 1'b0);
                2:       put(CH_SLASH, 1'b0);
                3:       put(CH_LPAREN, 1'b0);
                default: put(CH_RPAREN, 1'b0);
            endcase
        end else if (pick < 78) begin
            // comment up to newline, sometimes cut by end of input
            put(CH_SEMI, 1'b0);
            n = $urandom_range(0, 10);
            repeat (n) begin
                b = 8'($urandom_range(0, 254));
                if (b == CH_NL) b = CH_SPACE;
                put(b, 1'b0);
            end
            if ($urandom_range(0, 7) == 0) put(CH_EOI, 1'b0);
            else put(CH_NL, 1'b0);
        end else if (pick < 88) begin
            // raw noise over the whole character range
            put(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        end else if (pick < 93) begin
            if ($urandom_range(0, 1)) put(8'($urandom_range(0, 255)), 1'b1);
            else put(CH_EOI, 1'b0);
        end else begin
            put(CH_MINUS, 1'b0);
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: put(CH_SPACE, 1'b0);
            5:             put(CH_TAB, 1'b0);
            6, 7:          put(CH_NL, 1'b0);
            default:       begin end  // next lexeme butts up against this one
        endcase
    endtask

    // ----------------------------------------------------------- output side

    // receiver may drop tready for a random stall after each token beat, except while no_idle is set
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (m_axis_tready) begin
            if (m_axis_tvalid) begin
                rx_wait = no_idle ? 0 : $urandom_range(0, 4);
                if (rx_wait != 0) m_axis_tready <= 1'b0;
            end
        end else if (rx_wait <= 1) begin
            m_axis_tready <= 1'b1;
        end else begin
            rx_wait = rx_wait - 1;
        end
    end

    // compare each token beat with the oldest prediction
    always @(posedge aclk) begin : tok_monitor
        token_t seen;
        token_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            seen.kind = m_axis_tuser[3:0];
            seen.kw   = m_axis_tdata[0];
            seen.line = m_axis_tdata[16:1];
            seen.col  = m_axis_tdata[28:17];
            seen.len  = m_axis_tdata[40:29];
            seen.last = m_axis_tlast;
            if (tok_expected.size() == 0) begin
                report_failure({"unexpected token: ", tok_text(seen)});
            end else begin
                want = tok_expected.pop_front();
                kind_seen[want.kind]++;
                if (seen.kind !== want.kind || seen.kw !== want.kw ||
                    seen.line !== want.line || seen.col !== want.col ||
                    seen.len !== want.len || seen.last !== want.last)
                    report_failure({"token mismatch: expected ", tok_text(want),
                                    " got ", tok_text(seen)});
            end
        end
    end

    // -------------------------------------------------------------- stimulus

    function automatic row_t plain_row(logic [7:0] c, logic eoi);
        row_t r;
        r.c        = c;
        r.eoi      = eoi;
        r.given_ok = 1'b0;
        r.given    = '0;
        return r;
    endfunction

    // single-character token on line one, length one, last of its beat
    function automatic row_t known_row(logic [7:0] c, logic [3:0] kind, logic [11:0] col);
        row_t r;
        r          = plain_row(c, 1'b0);
        r.given_ok = 1'b1;
        r.given    = '{kind: kind, kw: 1'b0, line: 16'd1, col: col, len: 12'd1,
                       last: 1'b1};
        return r;
    endfunction

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) plan.push_back(plain_row(s[i], 1'b0));
    endtask

    initial begin
        sc       = SC_IDLE;
        cur_line = 16'd1;
        cur_col  = '0;
        tok_line = 16'd1;
        tok_col  = '0;
        lex_len  = '0;
        begin_ok = 1'b1;
        end_ok   = 1'b1;
        foreach (kind_seen[i]) kind_seen[i] = 0;

        // punctuation straight after reset, then the lowest and highest bad bytes
        plan.push_back(known_row(CH_COLON, KIND_COLON, 12'd0));
        plan.push_back(known_row(CH_COMMA, KIND_COMMA, 12'd1));
        plan.push_back(known_row(CH_SLASH, KIND_SLASH, 12'd2));
        plan.push_back(known_row(CH_LPAREN, KIND_LPAREN, 12'd3));
        plan.push_back(known_row(CH_RPAREN, KIND_RPAREN, 12'd4));
        plan.push_back(known_row(8'h00, KIND_BAD, 12'd5));
        plan.push_back(known_row(8'hFE, KIND_BAD, 12'd6));
        // keyword closed by a comma: two tokens from one beat
        add_text("BEGIN,");
        // keyword closed by minus, then digits and a dot make a float
        add_text("END-3.");
        plan.push_back(plain_row(CH_NL, 1'b0));
        // lone minus before a comment, comment cut by end of input
        plan.push_back(plain_row(CH_MINUS, 1'b0));
        plan.push_back(plain_row(CH_SEMI, 1'b0));
        plan.push_back(plain_row("x", 1'b1));
        // string spanning a newline
        plan.push_back(plain_row(CH_SQUOTE, 1'b0));
        plan.push_back(plain_row(CH_NL, 1'b0));
        plan.push_back(plain_row(CH_SQUOTE, 1'b0));
        // open string at end of input, then end of input once more
        plan.push_back(plain_row(CH_DQUOTE, 1'b0));
        plan.push_back(plain_row(CH_EOI, 1'b0));
        plan.push_back(plain_row(CH_EOI, 1'b0));
        plan.push_back(plain_row("z", 1'b0));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) send_char(plan[i].c, plan[i].eoi, plan[i].given_ok, plan[i].given);

        // random source text, with bursts where neither side idles
        while (chars_sent < plan.size() + RANDOM_CHARS) begin
            if ($urandom_range(0, 47) == 0) no_idle = !no_idle;
            random_token();
        end

        // close whatever token is still open
        put(8'h00, 1'b1);
        no_idle = 1'b0;
        s_axis_tvalid <= 1'b0;

        // let the token queue drain, then watch a little longer for strays
        for (int w = 0; w < DRAIN_LIMIT && tok_expected.size() != 0; w++)
            @(posedge aclk);
        if (tok_expected.size() != 0)
            report_failure($sformatf("%0d predicted tokens never arrived",
                                     tok_expected.size()));
        repeat (20) @(posedge aclk);

        $display("%0d characters scanned; tokens: ident %0d keyword %0d int %0d float %0d",
                 chars_sent, kind_seen[KIND_IDENT], kind_seen[KIND_KEYWORD],
                 kind_seen[KIND_INT], kind_seen[KIND_FLOAT]);
        $display("string %0d punct %0d end %0d bad %0d; %0d failures",
                 kind_seen[KIND_STRING],
                 kind_seen[KIND_COLON] + kind_seen[KIND_COMMA] + kind_seen[KIND_SLASH] +
                 kind_seen[KIND_LPAREN] + kind_seen[KIND_RPAREN],
                 kind_seen[KIND_END], kind_seen[KIND_BAD], fail_count);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
